>>> design/indexed_list_insert_delete_assert.svh
// Assertion macros for the indexed list block.
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTH

// expr must never hold outside reset
`define ILIST_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ilist: forbidden condition seen");

// cons must hold in the same cycle as ante
`define ILIST_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ilist: implication failed");

// cons must hold in the cycle after ante
`define ILIST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ilist: next-cycle check failed");

`else

`define ILIST_ASSERT_NEVER(label, clk, rst, expr)
`define ILIST_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ILIST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> design/ilist_pkg.sv
package ilist_pkg;

   localparam int DEPTH_DEF     = 16;
   localparam int WORD_BITS_DEF = 32;
   localparam int CNT_W_DEF     = $clog2(DEPTH_DEF + 1);

   localparam int FUNC_W = 3;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_POP    = 3'd5;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   // Qualified per-item commands broadcast along the row of cells
   typedef struct packed {
      logic append_en;
      logic insert_en;
      logic set_en;
      logic delete_en;
   } cmd_type;

endpackage

>>> design/indexed_list_insert_delete.sv
// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_func, req_position, req_value
// rsp       out        rsp_valid, rsp_ready, rsp_data, rsp_status, rsp_count
//
// Every operation, including insert and delete, is handled alike: all entry cells
// shift or load in parallel on the accepting edge and the result is registered.
// One item per cycle is sustained while rsp_ready stays high.
// req_ready drops only while a result waits in the output register and rsp_ready is low.
// Synchronous active-high reset empties the list; entry words are not cleared.
`include "indexed_list_insert_delete_assert.svh"

module indexed_list_insert_delete #(
   parameter int DEPTH     = ilist_pkg::DEPTH_DEF,
   parameter int WORD_BITS = ilist_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ilist_pkg::FUNC_W-1:0]      req_func,
   input  logic [$clog2(DEPTH+1)-1:0]        req_position,
   input  logic [WORD_BITS-1:0]              req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [WORD_BITS-1:0]              rsp_data,
   output logic [ilist_pkg::STATUS_W-1:0]    rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count
);
   import ilist_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]     fill_ff;
   logic [CNT_W-1:0]     fill_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic                 fire;
   logic                 full;
   logic                 empty;
   logic [STATUS_W-1:0]  status;
   logic                 rd_en;
   logic [CNT_W-1:0]     rd_idx;
   logic [WORD_BITS-1:0] rd_word;
   cmd_type              op;
   cmd_type              cmd;

   logic [WORD_BITS-1:0] words    [DEPTH];
   logic [WORD_BITS-1:0] rd_words [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign full      = (fill_ff == CNT_W'(DEPTH));
   assign empty     = (fill_ff == '0);

   // Decode and check the item against the current fill
   always_comb begin
      op      = '0;
      status  = ST_OK;
      rd_en   = 1'b0;
      rd_idx  = req_position;
      fill_in = fill_ff;
      unique case (req_func)
         FUNC_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op.append_en = 1'b1;
               fill_in      = fill_ff + CNT_W'(1);
            end
         end
         FUNC_INSERT: begin
            if (req_position > fill_ff) begin
               status = ST_INDEX;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               op.insert_en = 1'b1;
               fill_in      = fill_ff + CNT_W'(1);
            end
         end
         FUNC_SET: begin
            if (req_position >= fill_ff) begin
               status = ST_INDEX;
            end else begin
               op.set_en = 1'b1;
            end
         end
         FUNC_GET: begin
            if (req_position >= fill_ff) begin
               status = ST_INDEX;
            end else begin
               rd_en = 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (req_position >= fill_ff) begin
               status = ST_INDEX;
            end else begin
               op.delete_en = 1'b1;
               fill_in      = fill_ff - CNT_W'(1);
            end
         end
         FUNC_POP: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_idx  = fill_ff - CNT_W'(1);
               fill_in = fill_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd = fire ? op : '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] prev_word;
      logic [WORD_BITS-1:0] next_word;

      if (i == 0) begin : g_first
         assign prev_word = '0;
      end else begin : g_mid_lo
         assign prev_word = words[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_word = '0;
      end else begin : g_mid_hi
         assign next_word = words[i+1];
      end

      ilist_cell #(
         .WORD_BITS (WORD_BITS),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .idx       (CNT_W'(i)),
         .position  (req_position),
         .fill      (fill_ff),
         .rd_idx    (rd_idx),
         .value     (req_value),
         .prev_word (prev_word),
         .next_word (next_word),
         .word      (words[i]),
         .rd_word   (rd_words[i])
      );
   end

   // At most one cell matches the read index, so OR the row together
   always_comb begin
      rd_word = '0;
      for (int k = 0; k < DEPTH; k++) begin
         rd_word = rd_word | rd_words[k];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff   <= rd_en ? rd_word : '0;
         rsp_status_ff <= status;
         rsp_count_ff  <= fill_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   `ILIST_ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > CNT_W'(DEPTH))
   `ILIST_ASSERT_NEXT(a_append_grows, clock, reset,
      fire && (req_func == FUNC_APPEND) && !full, fill_ff == $past(fill_ff) + CNT_W'(1))
   `ILIST_ASSERT_IMPLIES(a_count_tracks, clock, reset, rsp_valid_ff, rsp_count_ff == fill_ff)
   `ILIST_ASSERT_IMPLIES(a_reject_no_data, clock, reset,
      rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_data_ff == '0)

endmodule

>>> design/ilist_cell.sv
module ilist_cell #(
   parameter int WORD_BITS = ilist_pkg::WORD_BITS_DEF,
   parameter int CNT_W     = ilist_pkg::CNT_W_DEF
) (
   input  logic                 clock,
   input  ilist_pkg::cmd_type   cmd,
   input  logic [CNT_W-1:0]     idx,
   input  logic [CNT_W-1:0]     position,
   input  logic [CNT_W-1:0]     fill,
   input  logic [CNT_W-1:0]     rd_idx,
   input  logic [WORD_BITS-1:0] value,
   input  logic [WORD_BITS-1:0] prev_word,
   input  logic [WORD_BITS-1:0] next_word,
   output logic [WORD_BITS-1:0] word,
   output logic [WORD_BITS-1:0] rd_word
);
   import ilist_pkg::*;

   logic [WORD_BITS-1:0] entry_ff;
   logic [WORD_BITS-1:0] entry_in;
   logic                 take_prev;
   logic                 take_next;
   logic                 load;

   always_comb begin
      take_prev = cmd.insert_en && (idx > position) && (idx <= fill);
      take_next = cmd.delete_en && (idx >= position) &&
                  (({1'b0, idx} + {{CNT_W{1'b0}}, 1'b1}) < {1'b0, fill});
      load      = (cmd.append_en && (idx == fill)) ||
                  ((cmd.insert_en || cmd.set_en) && (idx == position));
      entry_in  = entry_ff;
      if (take_prev) begin
         entry_in = prev_word;
      end else if (take_next) begin
         entry_in = next_word;
      end else if (load) begin
         entry_in = value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign word    = entry_ff;
   assign rd_word = (idx == rd_idx) ? entry_ff : '0;

endmodule
